// ===== rtl/page_bitmap_allocator_assert.svh =====
// assertion macros shared by the checker
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define PBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, codes and helpers of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int MAX_WORDS_DEF  = 256;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int ADDR_W   = 48;
  localparam int BYTES_W  = 32;
  localparam int PCOUNT_W = 15;
  localparam int RADDR_W  = 26;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 15;
  localparam int CFG_W    = 9;
  localparam int CHUNK_W  = 10;
  localparam int WORD_W   = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_CONSEC  = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_RESERVE = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd3;

  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic fill;
    logic emit;
  } pba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic quick;
    logic finish;
    logic to_fill;
    logic fill_last;
  } pba_sts_t;

  function automatic logic [5:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] w);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + 7'(w[i]);
    end
    return c;
  endfunction

endpackage

// ===== rtl/pba_controller.sv =====
// ----------------------------------------------------------------------------
// pba_controller
// Sequencer: clearing pass, command setup, word scan loop, run fill, result.
// ----------------------------------------------------------------------------
module pba_controller import pba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output pba_cmd_t cmd,
  input  pba_sts_t sts
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_READ  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_SETUP;
      S_SETUP: state_next = sts.quick ? S_DONE : S_READ;
      S_READ:  state_next = S_EVAL;
      S_EVAL: begin
        if (sts.to_fill) state_next = S_FILL;
        else if (sts.finish) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_FILL:  if (sts.fill_last) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign cmd.clear = (state == S_CLEAR);
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.eval  = (state == S_EVAL);
  assign cmd.fill  = (state == S_FILL);
  assign cmd.emit  = (state == S_DONE);

endmodule

// ===== rtl/pba_datapath.sv =====
// ----------------------------------------------------------------------------
// pba_datapath
// Bitmap memory, allocator state, range setup and per-word evaluation.
// ----------------------------------------------------------------------------
module pba_datapath import pba_pkg::*; #(
  parameter int MAX_WORDS  = MAX_WORDS_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pba_cmd_t            cmd,
  output pba_sts_t            sts,
  input  logic [2:0]          action,
  input  logic [ADDR_W-1:0]   address,
  input  logic [BYTES_W-1:0]  byte_count,
  input  logic [PCOUNT_W-1:0] pages_wanted,
  input  logic                cfg_write,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                done,
  output logic [RADDR_W-1:0]  result_address,
  output logic [STATUS_W-1:0] status,
  output logic                page_allocated,
  output logic [COUNT_W-1:0]  used_pages
);

  localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int MWW = $clog2(MAX_WORDS + 1);
  localparam int CW  = (MWW > CFG_W) ? MWW : CFG_W;
  localparam int KW  = ((CW > CHUNK_W) ? CW : CHUNK_W) + 1;
  localparam int PW  = ADDR_W - PAGE_SHIFT;
  localparam int EW  = PW + 2;
  localparam int SW  = BYTES_W + 1;

  logic [WORD_W-1:0] mem [MAX_WORDS];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wd;

  logic [CFG_W-1:0]    cfg_words;
  logic [WW-1:0]       next_word;
  logic [COUNT_W-1:0]  used_count;
  logic [2:0]          act;
  logic [CW-1:0]       cur, k, run_start, start_q, first_w, last_w;
  logic [5:0]          first_bit, last_bit;
  logic [CHUNK_W-1:0]  run_len, chunk, fill_left;
  logic                phase2, quick;
  logic [RADDR_W-1:0]  res_addr_q;
  logic [STATUS_W-1:0] status_q;
  logic                alloc_q;

  logic [CW-1:0]       cur_next, k_next, rs_next;
  logic [CHUNK_W-1:0]  rl_next, fl_next;
  logic                ph_next, fin, tofill;
  logic [WW-1:0]       nw_next;
  logic [COUNT_W-1:0]  used_next;
  logic [STATUS_W-1:0] st_next;
  logic                al_next;
  logic [RADDR_W-1:0]  ra_next;

  // setup values from the request
  logic [CW-1:0]       words, start_w, in_word;
  logic [EW-1:0]       total, end_m1, last_p;
  logic [PW-1:0]       in_page;
  logic [SW-1:0]       span_m1;
  logic                in_oor, cap;
  logic [CHUNK_W-1:0]  chunk_raw, chunk_in;
  logic                ld_quick, ld_alloc;
  logic [STATUS_W-1:0] ld_status;

  // per-word evaluation terms
  logic [CW-1:0]       cur_inc, new_rs;
  logic [CHUNK_W-1:0]  new_len;
  logic [KW-1:0]       rs_end;
  logic [5:0]          zbit, lo_b, hi_b;
  logic [WORD_W-1:0]   rmask;
  logic                wfree;

  function automatic logic [RADDR_W-1:0] page_addr(input logic [CW-1:0] w,
                                                   input logic [5:0] b);
    logic [63:0] t;
    t = ((64'(w) << 6) | 64'(b)) << PAGE_SHIFT;
    return t[RADDR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[cur[WW-1:0]] <= mem_wd;
    rdata <= mem[cur[WW-1:0]];
  end

  assign words   = (CW'(cfg_words) > CW'(MAX_WORDS)) ? CW'(MAX_WORDS) : CW'(cfg_words);
  assign total   = EW'(words) << 6;
  assign start_w = (CW'(next_word) < words) ? CW'(next_word) : '0;
  assign in_page = address[ADDR_W-1:PAGE_SHIFT];
  assign in_word = CW'(in_page >> 6);
  assign in_oor  = EW'(in_page) >= total;
  assign span_m1 = SW'(byte_count) + SW'(address[PAGE_SHIFT-1:0]) - SW'(1);
  assign end_m1  = EW'(in_page) + EW'(span_m1 >> PAGE_SHIFT);
  assign cap     = end_m1 >= total;
  assign last_p  = cap ? (total - EW'(1)) : end_m1;

  assign chunk_raw = CHUNK_W'((16'(pages_wanted) + 16'd63) >> 6);
  assign chunk_in  = (chunk_raw == '0) ? CHUNK_W'(1) : chunk_raw;

  always_comb begin
    ld_quick  = 1'b1;
    ld_status = ST_OK;
    ld_alloc  = 1'b0;
    case (action)
      ACT_ALLOC: begin
        ld_quick  = (words == '0);
        ld_status = (words == '0) ? ST_NOMEM : ST_OK;
      end
      ACT_CONSEC: begin
        ld_quick  = KW'(chunk_in) > KW'(words);
        ld_status = ld_quick ? ST_NOMEM : ST_OK;
      end
      ACT_FREE: begin
        ld_quick  = in_oor;
        ld_status = in_oor ? ST_RANGE : ST_OK;
      end
      ACT_QUERY: begin
        ld_quick  = in_oor;
        ld_status = in_oor ? ST_RANGE : ST_OK;
        ld_alloc  = in_oor;
      end
      ACT_RESERVE: begin
        ld_quick  = (byte_count == '0) || in_oor;
        ld_status = ((byte_count != '0) && cap) ? ST_RANGE : ST_OK;
      end
      default: begin
        ld_quick  = 1'b1;
        ld_status = ST_OK;
      end
    endcase
  end

  assign cur_inc = cur + CW'(1);
  assign wfree   = (rdata == '0);
  assign new_rs  = wfree ? run_start : cur_inc;
  assign new_len = wfree ? (run_len + CHUNK_W'(1)) : '0;
  assign rs_end  = KW'(run_start) + KW'(chunk);
  assign zbit    = lowest_zero(rdata);
  assign lo_b    = (cur == first_w) ? first_bit : 6'd0;
  assign hi_b    = (cur == last_w) ? last_bit : 6'd63;
  assign rmask   = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (6'd63 - hi_b));

  always_comb begin
    mem_we    = 1'b0;
    mem_wd    = '0;
    fin       = 1'b0;
    tofill    = 1'b0;
    cur_next  = cur;
    k_next    = k;
    rs_next   = run_start;
    rl_next   = run_len;
    ph_next   = phase2;
    fl_next   = fill_left;
    nw_next   = next_word;
    used_next = used_count;
    st_next   = status_q;
    al_next   = alloc_q;
    ra_next   = res_addr_q;
    if (cmd.clear) begin
      mem_we   = 1'b1;
      cur_next = cur_inc;
    end else if (cmd.fill) begin
      mem_we   = 1'b1;
      mem_wd   = '1;
      cur_next = cur_inc;
      fl_next  = fill_left - CHUNK_W'(1);
    end else if (cmd.eval) begin
      case (act)
        ACT_ALLOC: begin
          if (rdata != '1) begin
            mem_we    = 1'b1;
            mem_wd    = rdata | (WORD_W'(1) << zbit);
            nw_next   = WW'(cur);
            used_next = used_count + COUNT_W'(1);
            ra_next   = page_addr(cur, zbit);
            fin       = 1'b1;
          end else if ((k + CW'(1)) == words) begin
            st_next = ST_NOMEM;
            fin     = 1'b1;
          end else begin
            k_next   = k + CW'(1);
            cur_next = (cur_inc == words) ? '0 : cur_inc;
          end
        end
        ACT_CONSEC: begin
          if (wfree && ((run_len + CHUNK_W'(1)) == chunk)) begin
            tofill    = 1'b1;
            cur_next  = run_start;
            fl_next   = chunk;
            ra_next   = page_addr(run_start, 6'd0);
            used_next = used_count + COUNT_W'({chunk, 6'd0});
            nw_next   = (rs_end < KW'(words)) ? WW'(rs_end) : '0;
          end else if (cur_inc == words) begin
            // end of memory: wrap once to the words below the start
            if (phase2 || (start_q == '0)) begin
              st_next = ST_NOMEM;
              fin     = 1'b1;
            end else begin
              ph_next  = 1'b1;
              cur_next = '0;
              rs_next  = '0;
              rl_next  = '0;
            end
          end else if (phase2 && (new_rs >= start_q)) begin
            st_next = ST_NOMEM;
            fin     = 1'b1;
          end else begin
            cur_next = cur_inc;
            rs_next  = new_rs;
            rl_next  = new_len;
          end
        end
        ACT_FREE: begin
          fin = 1'b1;
          if (!rdata[first_bit]) begin
            st_next = ST_FREE;
          end else begin
            mem_we    = 1'b1;
            mem_wd    = rdata & ~(WORD_W'(1) << first_bit);
            used_next = used_count - COUNT_W'(1);
          end
        end
        ACT_QUERY: begin
          fin     = 1'b1;
          al_next = rdata[first_bit];
        end
        ACT_RESERVE: begin
          mem_we    = 1'b1;
          mem_wd    = rdata | rmask;
          used_next = used_count + COUNT_W'(popcount64(rmask & ~rdata));
          if (cur == last_w) fin = 1'b1;
          else cur_next = cur_inc;
        end
        default: fin = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_words      <= CFG_RESET;
      next_word      <= '0;
      used_count     <= '0;
      cur            <= '0;
      done           <= 1'b0;
      result_address <= '0;
      status         <= ST_OK;
      page_allocated <= 1'b0;
      used_pages     <= '0;
    end else begin
      if (cfg_write) cfg_words <= cfg_data;
      done <= cmd.emit;
      if (cmd.load) begin
        act       <= action;
        quick     <= ld_quick;
        status_q  <= ld_status;
        alloc_q   <= ld_alloc;
        res_addr_q <= '0;
        cur       <= ((action == ACT_ALLOC) || (action == ACT_CONSEC)) ? start_w : in_word;
        start_q   <= start_w;
        run_start <= start_w;
        run_len   <= '0;
        phase2    <= 1'b0;
        k         <= '0;
        chunk     <= chunk_in;
        first_w   <= in_word;
        first_bit <= in_page[5:0];
        last_w    <= CW'(last_p >> 6);
        last_bit  <= last_p[5:0];
      end else begin
        cur        <= cur_next;
        k          <= k_next;
        run_start  <= rs_next;
        run_len    <= rl_next;
        phase2     <= ph_next;
        fill_left  <= fl_next;
        next_word  <= nw_next;
        used_count <= used_next;
        status_q   <= st_next;
        alloc_q    <= al_next;
        res_addr_q <= ra_next;
      end
      if (cmd.emit) begin
        result_address <= res_addr_q;
        status         <= status_q;
        page_allocated <= alloc_q;
        used_pages     <= used_count;
      end
    end
  end

  assign sts.clear_last = (cur == CW'(MAX_WORDS - 1));
  assign sts.quick      = quick;
  assign sts.finish     = fin;
  assign sts.to_fill    = tofill;
  assign sts.fill_last  = (fill_left == CHUNK_W'(1));

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Next-fit page frame allocator over a bitmap of 64-page words.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low: action picks
// allocate page, allocate consecutive, free page, reserve range or query page.
// busy stays high until the result; one result beat follows each request,
// shown for exactly one cycle with done high. The receiver cannot stall.
// After setup, each word of the single-port bitmap is read, then evaluated:
//   free, query: one word; out of range or unknown: none.
//   allocate page: each word scanned.
//   allocate consecutive: each word scanned, then a fill step per run word.
//   reserve: each word touched by the byte range.
// Requests are handled one at a time; the next may be taken in the cycle
// done is high. words_in_use is written through cfg_write / cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// After reset a clearing pass zeroes the bitmap, one word a cycle, with busy
// high through the pass; next word, used count and words_in_use (256)
// reset at once.
// ----------------------------------------------------------------------------
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int MAX_WORDS  = MAX_WORDS_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          action,
  input  logic [ADDR_W-1:0]   address,
  input  logic [BYTES_W-1:0]  byte_count,
  input  logic [PCOUNT_W-1:0] pages_wanted,
  input  logic                cfg_write,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                done,
  output logic [RADDR_W-1:0]  result_address,
  output logic [STATUS_W-1:0] status,
  output logic                page_allocated,
  output logic [COUNT_W-1:0]  used_pages
);

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  pba_datapath #(
    .MAX_WORDS  (MAX_WORDS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .address        (address),
    .byte_count     (byte_count),
    .pages_wanted   (pages_wanted),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .done           (done),
    .result_address (result_address),
    .status         (status),
    .page_allocated (page_allocated),
    .used_pages     (used_pages)
  );

endmodule

// ===== rtl/pba_checker.sv =====
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the page bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_assert.svh"

module pba_checker import pba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [RADDR_W-1:0]  result_address,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  used_pages
);

  `PBA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "no busy after accepted beat")
  `PBA_ASSERT_NEXT(a_single_result, done, !done, "result beat lasted more than one cycle")
  `PBA_ASSERT_IMP(a_addr_only_ok, done && (result_address != '0), status == ST_OK, "address with error status")
  `PBA_ASSERT_IMP(a_count_holds, !done ##1 !done, $stable(used_pages), "used count moved without a result")

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (.*);

// ===== tb/tb_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator
// Self-checking bench for the next-fit page bitmap allocator: directed corner
// requests, then random request mixes over several memory sizes, each result
// beat compared field by field against an in-bench model of the bitmap.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  typedef struct packed {
    logic [RADDR_W-1:0]  raddr;
    logic [STATUS_W-1:0] st;
    logic                used;
    logic [COUNT_W-1:0]  count;
  } alloc_answer_t;

  class alloc_scoreboard;
    logic [WORD_W-1:0] bitmap [MAX_WORDS_DEF];
    int unsigned       next_word;
    int unsigned       used_count;
    logic [CFG_W-1:0]  words_cfg;
    alloc_answer_t     answers [$];
    int                errors;

    function void clear();
      foreach (bitmap[i]) bitmap[i] = '0;
      next_word  = 0;
      used_count = 0;
      words_cfg  = CFG_RESET;
      errors     = 0;
    endfunction

    function int unsigned word_total();
      return (words_cfg > MAX_WORDS_DEF) ? MAX_WORDS_DEF : words_cfg;
    endfunction

    function bit run_clear(int unsigned s, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (bitmap[s + i] != '0) return 0;
      return 1;
    endfunction

    // advance the model by one accepted request and queue its answer
    function void note_request(logic [2:0] act, logic [ADDR_W-1:0] addr,
                               logic [BYTES_W-1:0] nbytes, logic [PCOUNT_W-1:0] pcnt);
      int unsigned   words, first, spot, bitpos, chunk, s;
      longint unsigned total, page, span, last, p;
      bit            found;
      alloc_answer_t a;
      words = word_total();
      total = longint'(words) * 64;
      first = (next_word < words) ? next_word : 0;
      page  = addr >> PAGE_SHIFT_DEF;
      a     = '0;
      found = 0;
      case (act)
        ACT_ALLOC: begin
          spot = first;
          for (int unsigned k = 0; k < words; k++) begin
            if (bitmap[spot] != '1) begin
              found = 1;
              break;
            end
            spot = (spot + 1 >= words) ? 0 : spot + 1;
          end
          if (found) begin
            bitpos = 0;
            while (bitmap[spot][bitpos]) bitpos++;
            bitmap[spot][bitpos] = 1'b1;
            next_word = spot;
            used_count++;
            a.raddr = RADDR_W'((longint'(spot) * 64 + bitpos) << PAGE_SHIFT_DEF);
          end else a.st = ST_NOMEM;
        end
        ACT_CONSEC: begin
          chunk = (int'(pcnt) + 63) >> 6;
          if (chunk == 0) chunk = 1;
          if (chunk <= words) begin
            for (s = first; s + chunk <= words; s++)
              if (run_clear(s, chunk)) begin
                found = 1;
                break;
              end
            if (!found)
              for (s = 0; s < first && s + chunk <= words; s++)
                if (run_clear(s, chunk)) begin
                  found = 1;
                  break;
                end
            if (found) begin
              for (int unsigned i = 0; i < chunk; i++) bitmap[s + i] = '1;
              used_count += chunk * 64;
              next_word = (s + chunk < words) ? s + chunk : 0;
              a.raddr = RADDR_W'((longint'(s) * 64) << PAGE_SHIFT_DEF);
            end
          end
          if (!found) a.st = ST_NOMEM;
        end
        ACT_FREE: begin
          if (page >= total) a.st = ST_RANGE;
          else if (!bitmap[page >> 6][page & 63]) a.st = ST_FREE;
          else begin
            bitmap[page >> 6][page & 63] = 1'b0;
            used_count--;
          end
        end
        ACT_RESERVE: begin
          if (nbytes != 0) begin
            span = longint'(nbytes) + (addr & 48'hFFF);
            last = page + ((span - 1) >> PAGE_SHIFT_DEF) + 1;
            if (last > total) begin
              a.st = ST_RANGE;
              last = total;
            end
            for (p = page; p < last; p++)
              if (!bitmap[p >> 6][p & 63]) begin
                bitmap[p >> 6][p & 63] = 1'b1;
                used_count++;
              end
          end
        end
        ACT_QUERY: begin
          if (page >= total) begin
            a.st   = ST_RANGE;
            a.used = 1'b1;
          end else a.used = bitmap[page >> 6][page & 63];
        end
        default: ;
      endcase
      a.count = COUNT_W'(used_count);
      answers.push_back(a);
    endfunction

    function void check_result(alloc_answer_t got);
      alloc_answer_t want;
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing pending: %p", got);
        return;
      end
      want = answers.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch addr %h/%h status %0d/%0d alloc %b/%b used %0d/%0d (exp/act)",
                   want.raddr, got.raddr, want.st, got.st, want.used, got.used,
                   want.count, got.count);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          action = '0;
  logic [ADDR_W-1:0]   address = '0;
  logic [BYTES_W-1:0]  byte_count = '0;
  logic [PCOUNT_W-1:0] pages_wanted = '0;
  logic                cfg_write = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                done;
  logic [RADDR_W-1:0]  result_address;
  logic [STATUS_W-1:0] status;
  logic                page_allocated;
  logic [COUNT_W-1:0]  used_pages;

  alloc_scoreboard sb;

  page_bitmap_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .address(address), .byte_count(byte_count), .pages_wanted(pages_wanted),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .result_address(result_address), .status(status),
    .page_allocated(page_allocated), .used_pages(used_pages)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("page_bitmap_allocator test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(action, address, byte_count, pages_wanted);
      if (done) sb.check_result({result_address, status, page_allocated, used_pages});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send(logic [2:0] act, logic [ADDR_W-1:0] addr,
                      logic [BYTES_W-1:0] nbytes, logic [PCOUNT_W-1:0] pcnt, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    address      <= addr;
    byte_count   <= nbytes;
    pages_wanted <= pcnt;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_words(logic [CFG_W-1:0] w);
    start <= 1'b0;
    @(posedge clk);
    while (sb.answers.size() != 0 || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.words_cfg = w;
  endtask

  // mostly installed pages, sometimes any address
  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned pages;
    logic [ADDR_W-1:0] a;
    pages = sb.word_total() * 64;
    a = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(3) == 0 || pages == 0) return a;
    return (ADDR_W'($urandom_range(pages + 1)) << PAGE_SHIFT_DEF) | (a & 48'hFFF);
  endfunction

  task automatic random_burst(int n);
    int r;
    logic [2:0] act;
    logic [BYTES_W-1:0] nb;
    logic [PCOUNT_W-1:0] pc;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 28) act = ACT_ALLOC;
      else if (r < 38) act = ACT_CONSEC;
      else if (r < 68) act = ACT_FREE;
      else if (r < 78) act = ACT_RESERVE;
      else if (r < 96) act = ACT_QUERY;
      else act = 3'($urandom_range(7, 5));
      nb = ($urandom_range(15) == 0) ? BYTES_W'($urandom) : BYTES_W'($urandom_range(20000));
      pc = ($urandom_range(7) == 0) ? PCOUNT_W'($urandom) : PCOUNT_W'($urandom_range(300));
      send(act, pick_addr(), nb, pc, (i % 100 < 30) ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sizes [8] = '{9'd1, 9'd0, 9'd4, 9'd300, 9'd2, 9'd256, 9'd16, 9'd511};
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners at full size
    send(ACT_QUERY,   '0, '0, '0, 0);
    send(ACT_ALLOC,   '0, '0, '0, 0);
    send(ACT_ALLOC,   '0, '0, '0, 1);
    send(ACT_CONSEC,  '0, '0, 15'd0, 0);
    send(ACT_CONSEC,  '0, '0, 15'd16384, 0);
    send(ACT_CONSEC,  '0, '0, 15'h7FFF, 2);
    send(ACT_CONSEC,  '0, '0, 15'd64, 0);
    send(ACT_FREE,    48'h0, '0, '0, 0);
    send(ACT_FREE,    48'h0, '0, '0, 0);
    send(ACT_FREE,    '1, '0, '0, 0);
    send(ACT_QUERY,   '1, '0, '0, 0);
    send(ACT_RESERVE, 48'h5FFF, 32'd0, '0, 0);
    send(ACT_RESERVE, 48'h5FFF, 32'd2, '0, 0);
    send(ACT_RESERVE, 48'h0, '1, '0, 0);
    send(ACT_ALLOC,   '0, '0, '0, 0);
    send(ACT_CONSEC,  '0, '0, 15'd1, 0);
    send(ACT_FREE,    48'h64123, '0, '0, 0);
    send(ACT_QUERY,   48'h64000, '0, '0, 0);
    send(ACT_ALLOC,   '0, '0, '0, 0);
    send(3'd5, '1, '1, '1, 0);
    send(3'd6, '0, '0, '0, 0);
    send(3'd7, '1, '1, '1, 0);
    send(ACT_RESERVE, 48'hFFF_FFFF_F000, '1, '0, 0);

    foreach (sizes[k]) begin
      set_words(sizes[k]);
      if (sizes[k] == 9'd0) begin
        send(ACT_ALLOC, '0, '0, '0, 0);
        send(ACT_CONSEC, '0, '0, 15'd1, 0);
        send(ACT_QUERY, '0, '0, '0, 0);
      end
      random_burst(sizes[k] == 9'd0 ? 40 : 250);
    end

    start <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("page_bitmap_allocator test passed");
    else $display("page_bitmap_allocator test failed");
    $finish;
  end

endmodule
